// File: hdl/cht_pkg.sv
package cht_pkg;

   // request actions
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   // reciprocal of ten for a 32-bit dividend, quotient is product >> 35
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] bucket;
   } rsp_type;

endpackage

// File: hdl/cht_ram.sv
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cht_hash.sv
module cht_hash #(
   parameter int BUCKETS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                value,
   output logic                       done,
   output logic [$clog2(BUCKETS)-1:0] key
);

   localparam int KW  = $clog2(BUCKETS);
   localparam int TRW = KW + 6;

   typedef enum logic [2:0] {
      H_IDLE = 3'b001,
      H_DIV  = 3'b010,
      H_ACC  = 3'b100
   } hash_state_type;

   hash_state_type state_ff, state_in;
   logic [31:0]    raw_ff, raw_in;
   logic [31:0]    quot_ff, quot_in;
   logic [KW-1:0]  key_ff, key_in;
   logic           done_ff, done_in;

   logic [63:0]    prod;
   logic [31:0]    ten_q;
   logic [31:0]    diff;
   logic [TRW-1:0] acc;

   always_comb begin
      prod  = {32'd0, raw_ff} * {32'd0, cht_pkg::RECIP_TEN};
      ten_q = (quot_ff << 3) + (quot_ff << 1);
      diff  = raw_ff - ten_q;
      // key*31 + digit, then reduce below BUCKETS by binary steps
      acc   = (TRW'(key_ff) << 5) - TRW'(key_ff) + TRW'(diff[3:0]);
      for (int k = 4; k >= 0; k--) begin
         if (acc >= TRW'(BUCKETS << k)) begin
            acc = acc - TRW'(BUCKETS << k);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      raw_in   = raw_ff;
      quot_in  = quot_ff;
      key_in   = key_ff;
      done_in  = 1'b0;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               key_in = '0;
               raw_in = value;
               if (value[31] || value == 32'd0) begin
                  done_in = 1'b1;
               end else begin
                  state_in = H_DIV;
               end
            end
         end
         H_DIV: begin
            quot_in  = {3'd0, prod[63:cht_pkg::RECIP_SHIFT]};
            state_in = H_ACC;
         end
         H_ACC: begin
            key_in = acc[KW-1:0];
            raw_in = quot_ff;
            if (quot_ff == 32'd0) begin
               done_in  = 1'b1;
               state_in = H_IDLE;
            end else begin
               state_in = H_DIV;
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      raw_ff  <= raw_in;
      quot_ff <= quot_in;
      key_ff  <= key_in;
   end

   assign done = done_ff;
   assign key  = key_ff;

endmodule

// File: hdl/chained_hash_table.sv
// channel | ports                                 | item
// req     | req_valid, req_stall (out), req_payload | action and signed value
// rsp     | rsp_valid, rsp_stall (in), rsp_payload  | status and bucket
//
// one item at a time; hashing takes a divide step and an accumulate step per decimal digit,
// then insert reads, writes and links the slot, delete walks the chain, then unlinks and frees
// clear sweeps every index below max(BUCKETS, POOL_SLOTS) through the link memories;
// the same sweep runs after reset, req_stall stays high meanwhile
// a finished item waits in the output register while rsp_stall is high
module chained_hash_table #(
   parameter int BUCKETS    = 10,
   parameter int POOL_SLOTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cht_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cht_pkg::rsp_type rsp_payload
);

   localparam int KW        = $clog2(BUCKETS);
   localparam int AW        = $clog2(POOL_SLOTS);
   localparam int LW        = $clog2(POOL_SLOTS + 1);
   localparam int SWEEP_MAX = (BUCKETS > POOL_SLOTS) ? BUCKETS : POOL_SLOTS;
   localparam int SW        = $clog2(SWEEP_MAX);
   localparam int CW        = $clog2(POOL_SLOTS + 1);
   localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);

   typedef enum logic [12:0] {
      ST_SWEEP    = 13'b0000000000001,
      ST_IDLE     = 13'b0000000000010,
      ST_HASH     = 13'b0000000000100,
      ST_INS_RD   = 13'b0000000001000,
      ST_INS_WR   = 13'b0000000010000,
      ST_INS_LINK = 13'b0000000100000,
      ST_DEL_HEAD = 13'b0000001000000,
      ST_DEL_CUR  = 13'b0000010000000,
      ST_DEL_CHK  = 13'b0000100000000,
      ST_DEL_CMP  = 13'b0001000000000,
      ST_DEL_UNL  = 13'b0010000000000,
      ST_DEL_FREE = 13'b0100000000000,
      ST_RESP     = 13'b1000000000000
   } state_type;

   state_type     state_ff, state_in;
   logic [1:0]    action_ff, action_in;
   logic [31:0]   value_ff, value_in;
   logic [KW-1:0] bucket_ff, bucket_in;
   logic [1:0]    status_ff, status_in;
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] cur_ff, cur_in;     // working slot (insert target or delete walk)
   logic [LW-1:0] old_ff, old_in;     // previous chain head on insert
   logic [LW-1:0] prv_ff, prv_in;
   logic [LW-1:0] nxt_ff, nxt_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic          clearing_ff, clearing_in;  // sweep was asked by a clear item
   logic          rsp_valid_ff, rsp_valid_in;
   cht_pkg::rsp_type rsp_ff, rsp_in;

   // hash unit
   logic          hash_start;
   logic          hash_done;
   logic [KW-1:0] hash_key;

   // memory ports
   logic          head_we;
   logic [KW-1:0] head_waddr;
   logic [LW-1:0] head_wdata;
   logic [LW-1:0] head_rd;
   logic          next_we;
   logic [AW-1:0] next_waddr;
   logic [LW-1:0] next_wdata;
   logic [LW-1:0] next_rd;
   logic          prev_we;
   logic [AW-1:0] prev_waddr;
   logic [LW-1:0] prev_wdata;
   logic [LW-1:0] prev_rd;
   logic          val_we;
   logic [31:0]   val_rd;
   logic [AW-1:0] slot_raddr;
   logic [KW+3:0] bucket_wide;

   cht_hash #(.BUCKETS(BUCKETS)) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .value (req_payload.value),
      .done  (hash_done),
      .key   (hash_key)
   );

   cht_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (bucket_ff),
      .rd_data (head_rd)
   );

   cht_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (slot_raddr),
      .rd_data (next_rd)
   );

   cht_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_addr (slot_raddr),
      .rd_data (prev_rd)
   );

   // slot values have no reset, only written on insert
   cht_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (cur_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_addr (slot_raddr),
      .rd_data (val_rd)
   );

   assign slot_raddr = cur_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      value_in     = value_ff;
      bucket_in    = bucket_ff;
      status_in    = status_ff;
      free_head_in = free_head_ff;
      cur_in       = cur_ff;
      old_in       = old_ff;
      prv_in       = prv_ff;
      nxt_in       = nxt_ff;
      steps_in     = steps_ff;
      sweep_in     = sweep_ff;
      clearing_in  = clearing_ff;
      rsp_in       = rsp_ff;
      hash_start   = 1'b0;
      head_we      = 1'b0;
      head_waddr   = bucket_ff;
      head_wdata   = NIL;
      next_we      = 1'b0;
      next_waddr   = cur_ff[AW-1:0];
      next_wdata   = NIL;
      prev_we      = 1'b0;
      prev_waddr   = cur_ff[AW-1:0];
      prev_wdata   = NIL;
      val_we       = 1'b0;
      bucket_wide  = (KW + 4)'(bucket_ff);

      // output register drains independently of the sequencer
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_SWEEP: begin
            // rebuild free list and empty every chain, one index a cycle
            if ({1'b0, sweep_ff} < (SW + 1)'(POOL_SLOTS)) begin
               next_we    = 1'b1;
               next_waddr = sweep_ff[AW-1:0];
               next_wdata = LW'(sweep_ff) + LW'(1);
               prev_we    = 1'b1;
               prev_waddr = sweep_ff[AW-1:0];
            end
            if ({1'b0, sweep_ff} < (SW + 1)'(BUCKETS)) begin
               head_we    = 1'b1;
               head_waddr = sweep_ff[KW-1:0];
            end
            free_head_in = '0;
            if (sweep_ff == SW'(SWEEP_MAX - 1)) begin
               sweep_in = '0;
               if (clearing_ff) begin
                  clearing_in = 1'b0;
                  state_in    = ST_RESP;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + SW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               action_in = req_payload.action;
               value_in  = req_payload.value;
               status_in = cht_pkg::STATUS_OK;
               bucket_in = '0;
               case (req_payload.action)
                  cht_pkg::ACT_INSERT, cht_pkg::ACT_DELETE: begin
                     hash_start = 1'b1;
                     state_in   = ST_HASH;
                  end
                  cht_pkg::ACT_CLEAR: begin
                     clearing_in = 1'b1;
                     sweep_in    = '0;
                     state_in    = ST_SWEEP;
                  end
                  default: state_in = ST_RESP;  // unused action changes nothing and only answers OK
               endcase
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               bucket_in = hash_key;
               steps_in  = '0;
               if (action_ff == cht_pkg::ACT_INSERT) begin
                  cur_in = free_head_ff;
                  if (free_head_ff >= NIL) begin
                     status_in = cht_pkg::STATUS_FULL;
                     state_in  = ST_RESP;
                  end else begin
                     state_in = ST_INS_RD;
                  end
               end else begin
                  state_in = ST_DEL_HEAD;
               end
            end
         end
         ST_INS_RD: begin
            // next of the free slot and the bucket head are read here
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            free_head_in = next_rd;
            old_in       = head_rd;
            val_we       = 1'b1;
            next_we      = 1'b1;
            next_wdata   = head_rd;
            prev_we      = 1'b1;
            head_we      = 1'b1;
            head_wdata   = cur_ff;
            state_in     = ST_INS_LINK;
         end
         ST_INS_LINK: begin
            if (old_ff < NIL) begin
               prev_we    = 1'b1;
               prev_waddr = old_ff[AW-1:0];
               prev_wdata = cur_ff;
            end
            state_in = ST_RESP;
         end
         ST_DEL_HEAD: begin
            state_in = ST_DEL_CUR;
         end
         ST_DEL_CUR: begin
            cur_in   = head_rd;
            state_in = ST_DEL_CHK;
         end
         ST_DEL_CHK: begin
            // walk bounded by the pool size
            if (cur_ff >= NIL || steps_ff >= CW'(POOL_SLOTS)) begin
               status_in = cht_pkg::STATUS_NOT_FOUND;
               state_in  = ST_RESP;
            end else begin
               state_in = ST_DEL_CMP;
            end
         end
         ST_DEL_CMP: begin
            if (val_rd == value_ff) begin
               prv_in   = prev_rd;
               nxt_in   = next_rd;
               state_in = ST_DEL_UNL;
            end else begin
               cur_in   = next_rd;
               steps_in = steps_ff + CW'(1);
               state_in = ST_DEL_CHK;
            end
         end
         ST_DEL_UNL: begin
            if (prv_ff < NIL) begin
               next_we    = 1'b1;
               next_waddr = prv_ff[AW-1:0];
               next_wdata = nxt_ff;
            end else begin
               head_we    = 1'b1;
               head_wdata = nxt_ff;
            end
            if (nxt_ff < NIL) begin
               prev_we    = 1'b1;
               prev_waddr = nxt_ff[AW-1:0];
               prev_wdata = prv_ff;
            end
            state_in = ST_DEL_FREE;
         end
         ST_DEL_FREE: begin
            // unlinked slot goes back on top of the free list
            prev_we      = 1'b1;
            next_we      = 1'b1;
            next_wdata   = free_head_ff;
            free_head_in = cur_ff;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.bucket = bucket_wide[3:0];
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         clearing_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clearing_ff  <= clearing_in;
         rsp_valid_ff <= rsp_valid_in;
         free_head_ff <= free_head_in;
      end
      action_ff <= action_in;
      value_ff  <= value_in;
      bucket_ff <= bucket_in;
      status_ff <= status_in;
      cur_ff    <= cur_in;
      old_ff    <= old_in;
      prv_ff    <= prv_in;
      nxt_ff    <= nxt_in;
      steps_ff  <= steps_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
